// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define BVM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition that must hold at every clock edge out of reset.
`define BVM_ASSERT_ALWAYS(lbl, expr, msg) \
    `BVM_ASSERT(lbl, 1'b1 |-> (expr), msg)

`endif

// ===== hdl/bvm_pkg.sv =====
package bvm_pkg;

    localparam int unsigned REG_ADDR_W = 8;
    localparam logic [REG_ADDR_W-1:0] REG_LAST = 8'hFF;
    localparam logic [REG_ADDR_W-1:0] REG_CMP  = 8'd0;
    localparam logic [REG_ADDR_W-1:0] REG_ARG  = 8'd1;
    localparam logic [7:0] JNZ_VALUE = 8'd2;

    localparam logic [3:0] OP_MOVE  = 4'd1;
    localparam logic [3:0] OP_LDI   = 4'd2;
    localparam logic [3:0] OP_PRINT = 4'd4;
    localparam logic [3:0] OP_ADD   = 4'd6;
    localparam logic [3:0] OP_SUB   = 4'd7;
    localparam logic [3:0] OP_MUL   = 4'd8;
    localparam logic [3:0] OP_DIV   = 4'd9;
    localparam logic [3:0] OP_JMP   = 4'd10;
    localparam logic [3:0] OP_CMP   = 4'd11;
    localparam logic [3:0] OP_JE    = 4'd12;
    localparam logic [3:0] OP_JNE   = 4'd13;
    localparam logic [3:0] OP_JNZ   = 4'd14;
    localparam logic [3:0] OP_DRAW  = 4'd15;

    localparam logic [2:0] EV_NONE  = 3'd0;
    localparam logic [2:0] EV_CLEAR = 3'd1;
    localparam logic [2:0] EV_HOME  = 3'd2;
    localparam logic [2:0] EV_PRINT = 3'd3;
    localparam logic [2:0] EV_PIXEL = 3'd4;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_DIV_ZERO  = 2'd1;
    localparam logic [1:0] ERR_BAD_INDEX = 2'd2;

    typedef struct packed {
        logic [3:0] kind;
        logic [9:0] first_operand;
        logic [7:0] second_operand;
    } t_in;

    typedef struct packed {
        logic              branch_taken;
        logic [9:0]        branch_target;
        logic [1:0]        words_used;
        logic [2:0]        display_event;
        logic signed [7:0] event_x;
        logic signed [7:0] event_y;
        logic signed [7:0] event_color;
        logic [1:0]        error_code;
    } t_out;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV,
        ALU_CMP
    } t_alu_op;

    typedef struct packed {
        logic              start;
        t_alu_op           op;
        logic signed [7:0] x;
        logic signed [7:0] y;
    } t_alu_req;

    typedef struct packed {
        logic              done;
        logic              div_zero;
        logic signed [7:0] result;
    } t_alu_rsp;

    typedef struct packed {
        logic [REG_ADDR_W-1:0] rd_addr;
        logic                  wr_en;
        logic [REG_ADDR_W-1:0] wr_addr;
        logic [7:0]            wr_data;
    } t_rf_req;

endpackage

// ===== hdl/bvm_regfile.sv =====
module bvm_regfile (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bvm_pkg::t_rf_req i_req,
    output logic [7:0]       o_rd_data
);

    localparam int unsigned DEPTH = 2 ** bvm_pkg::REG_ADDR_W;

    logic [7:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_data <= r_valid[i_req.rd_addr] ? r_mem[i_req.rd_addr] : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/bvm_alu.sv =====
`include "assert_macros.svh"

module bvm_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bvm_pkg::t_alu_req i_req,
    output bvm_pkg::t_alu_rsp o_rsp
);

    typedef enum logic {
        S_IDLE,
        S_DIV
    } t_state;

    t_state            r_state;
    logic [2:0]        r_cnt;
    logic [7:0]        r_rem;
    logic [7:0]        r_quo;
    logic [7:0]        r_div;
    logic              r_neg;
    logic              r_done;
    logic              r_dz;
    logic signed [7:0] r_result;

    logic signed [15:0] prod;
    logic signed [7:0]  quick;
    logic [7:0]         mag_x;
    logic [7:0]         mag_y;
    logic [8:0]         rem_sh;
    logic [9:0]         diff;
    logic               fits;
    logic [7:0]         n_rem;
    logic [7:0]         n_quo;

    always_comb begin
        prod = i_req.x * i_req.y;
        unique case (i_req.op)
            bvm_pkg::ALU_ADD: quick = i_req.x + i_req.y;
            bvm_pkg::ALU_SUB: quick = i_req.x - i_req.y;
            bvm_pkg::ALU_MUL: quick = prod[7:0];
            bvm_pkg::ALU_CMP: begin
                if (i_req.x == i_req.y) begin
                    quick = 8'sd0;
                end else if (i_req.x < i_req.y) begin
                    quick = -8'sd1;
                end else begin
                    quick = 8'sd1;
                end
            end
            default: quick = 8'sd0;
        endcase
        mag_x = i_req.x[7] ? 8'(-i_req.x) : 8'(i_req.x);
        mag_y = i_req.y[7] ? 8'(-i_req.y) : 8'(i_req.y);
        rem_sh = {r_rem, r_quo[7]};
        diff = {1'b0, rem_sh} - {2'b00, r_div};
        fits = !diff[9];
        n_rem = fits ? diff[7:0] : rem_sh[7:0];
        n_quo = {r_quo[6:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_dz    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        if (i_req.op != bvm_pkg::ALU_DIV) begin
                            r_result <= quick;
                            r_dz     <= 1'b0;
                            r_done   <= 1'b1;
                        end else if (i_req.y == 8'sd0) begin
                            r_dz   <= 1'b1;
                            r_done <= 1'b1;
                        end else begin
                            r_dz    <= 1'b0;
                            r_done  <= 1'b0;
                            r_rem   <= 8'd0;
                            r_quo   <= mag_x;
                            r_div   <= mag_y;
                            r_neg   <= i_req.x[7] ^ i_req.y[7];
                            r_cnt   <= 3'd0;
                            r_state <= S_DIV;
                        end
                    end else begin
                        r_done <= 1'b0;
                    end
                end
                S_DIV: begin
                    r_rem  <= n_rem;
                    r_quo  <= n_quo;
                    r_cnt  <= r_cnt + 3'd1;
                    r_done <= (r_cnt == 3'd7);
                    if (r_cnt == 3'd7) begin
                        r_result <= r_neg ? 8'(-n_quo) : 8'(n_quo);
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.div_zero = r_dz;
    assign o_rsp.result   = r_result;

    `BVM_ASSERT(a_no_start_busy, (r_state == S_DIV) |-> !i_req.start, "start while dividing")
    `BVM_ASSERT(a_done_pulse, r_done |=> !r_done, "done held longer than one cycle")
    `BVM_ASSERT(a_dz_div_only, (r_done && r_dz) |-> (r_state == S_IDLE), "divide-by-zero while busy")

endmodule

// ===== hdl/byte_register_vm_execute_unit.sv =====
// Executes one decoded instruction per input beat against 256 signed byte registers,
// all zero after reset, and returns one result beat per instruction. The unit takes
// a new instruction only when the previous one has finished; an output register
// holds a finished result so the next instruction can start while it waits. The
// register file has a single read port, so each operand is read in turn through a
// read and a capture state; an instruction with a register index above 255 goes
// straight to the done state, and divide runs through an 8-step restoring divider
// in the same unit as add, subtract, multiply and compare. A result that still
// waits in the output register holds the unit in its done state until that beat
// is taken.
`include "assert_macros.svh"

module byte_register_vm_execute_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  bvm_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output bvm_pkg::t_out o_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CAPT,
        S_EXEC,
        S_ALU,
        S_DONE
    } t_state;

    t_state        r_state;
    logic [3:0]    r_op;
    logic [9:0]    r_a;
    logic [7:0]    r_b;
    logic [1:0]    r_idx;
    logic [2:0]    r_nrd;
    logic [7:0]    r_opnd [4];
    logic [1:0]    r_err;
    logic          r_out_valid;
    bvm_pkg::t_out r_out;

    bvm_pkg::t_out     n_out;
    bvm_pkg::t_rf_req  rf_req;
    logic [7:0]        rf_rd_data;
    bvm_pkg::t_alu_req alu_req;
    bvm_pkg::t_alu_rsp alu_rsp;
    logic              in_bad;

    function automatic logic is_arith(input logic [3:0] op);
        return op == bvm_pkg::OP_ADD || op == bvm_pkg::OP_SUB ||
               op == bvm_pkg::OP_MUL || op == bvm_pkg::OP_DIV;
    endfunction

    function automatic logic uses_index(input logic [3:0] op);
        return is_arith(op) || op == bvm_pkg::OP_MOVE || op == bvm_pkg::OP_LDI ||
               op == bvm_pkg::OP_CMP;
    endfunction

    function automatic logic [2:0] read_count(input logic [3:0] op);
        logic [2:0] n;
        n = 3'd0;
        if (is_arith(op) || op == bvm_pkg::OP_CMP) begin
            n = 3'd2;
        end else if (op == bvm_pkg::OP_DRAW) begin
            n = 3'd4;
        end else if (op == bvm_pkg::OP_MOVE || op == bvm_pkg::OP_PRINT ||
                     op == bvm_pkg::OP_JE || op == bvm_pkg::OP_JNE ||
                     op == bvm_pkg::OP_JNZ) begin
            n = 3'd1;
        end
        return n;
    endfunction

    bvm_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (rf_req),
        .o_rd_data (rf_rd_data)
    );

    bvm_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    assign in_bad = uses_index(i_data.kind) &&
                    (i_data.first_operand > {2'b00, bvm_pkg::REG_LAST});

    always_comb begin
        unique case (r_op)
            bvm_pkg::OP_MOVE: rf_req.rd_addr = r_a[7:0];
            bvm_pkg::OP_ADD, bvm_pkg::OP_SUB, bvm_pkg::OP_MUL, bvm_pkg::OP_DIV: begin
                rf_req.rd_addr = (r_idx == 2'd0) ? r_a[7:0] : r_b;
            end
            bvm_pkg::OP_CMP: rf_req.rd_addr = (r_idx == 2'd0) ? bvm_pkg::REG_ARG : r_a[7:0];
            bvm_pkg::OP_DRAW: rf_req.rd_addr = {6'd0, r_idx};
            default: rf_req.rd_addr = bvm_pkg::REG_CMP;
        endcase

        rf_req.wr_en   = 1'b0;
        rf_req.wr_addr = r_a[7:0];
        rf_req.wr_data = r_opnd[0];
        if (r_state == S_EXEC && r_op == bvm_pkg::OP_MOVE) begin
            rf_req.wr_en   = 1'b1;
            rf_req.wr_addr = r_b;
        end else if (r_state == S_EXEC && r_op == bvm_pkg::OP_LDI) begin
            rf_req.wr_en   = 1'b1;
            rf_req.wr_data = r_b;
        end else if (r_state == S_ALU && alu_rsp.done && !alu_rsp.div_zero) begin
            rf_req.wr_en   = 1'b1;
            rf_req.wr_addr = (r_op == bvm_pkg::OP_CMP) ? bvm_pkg::REG_CMP : r_a[7:0];
            rf_req.wr_data = alu_rsp.result;
        end

        alu_req.start = (r_state == S_EXEC) && (is_arith(r_op) || r_op == bvm_pkg::OP_CMP);
        alu_req.x     = r_opnd[0];
        alu_req.y     = r_opnd[1];
        unique case (r_op)
            bvm_pkg::OP_SUB: alu_req.op = bvm_pkg::ALU_SUB;
            bvm_pkg::OP_MUL: alu_req.op = bvm_pkg::ALU_MUL;
            bvm_pkg::OP_DIV: alu_req.op = bvm_pkg::ALU_DIV;
            bvm_pkg::OP_CMP: alu_req.op = bvm_pkg::ALU_CMP;
            default:         alu_req.op = bvm_pkg::ALU_ADD;
        endcase
    end

    always_comb begin
        n_out = '0;
        n_out.error_code = r_err;
        if (is_arith(r_op) || r_op == bvm_pkg::OP_MOVE || r_op == bvm_pkg::OP_LDI) begin
            n_out.words_used = 2'd3;
        end else if (r_op == bvm_pkg::OP_JMP || r_op == bvm_pkg::OP_CMP ||
                     r_op == bvm_pkg::OP_JE || r_op == bvm_pkg::OP_JNE ||
                     r_op == bvm_pkg::OP_JNZ) begin
            n_out.words_used = 2'd2;
        end else begin
            n_out.words_used = 2'd1;
        end
        unique case (r_op)
            bvm_pkg::OP_JMP: n_out.branch_taken = 1'b1;
            bvm_pkg::OP_JE:  n_out.branch_taken = (r_opnd[0] == 8'd0);
            bvm_pkg::OP_JNE: n_out.branch_taken = (r_opnd[0] != 8'd0);
            bvm_pkg::OP_JNZ: n_out.branch_taken = (r_opnd[0] == bvm_pkg::JNZ_VALUE);
            default:         n_out.branch_taken = 1'b0;
        endcase
        n_out.branch_target = n_out.branch_taken ? r_a : 10'd0;
        if (r_op == bvm_pkg::OP_PRINT) begin
            if (r_opnd[0] == 8'd0) begin
                n_out.display_event = bvm_pkg::EV_HOME;
            end else begin
                n_out.display_event = bvm_pkg::EV_PRINT;
                n_out.event_x       = r_opnd[0];
            end
        end else if (r_op == bvm_pkg::OP_DRAW) begin
            if (r_opnd[0] == 8'd0) begin
                n_out.display_event = bvm_pkg::EV_CLEAR;
            end else if (r_opnd[0] == 8'd1) begin
                n_out.display_event = bvm_pkg::EV_PIXEL;
                n_out.event_x       = r_opnd[1];
                n_out.event_y       = r_opnd[2];
                n_out.event_color   = r_opnd[3];
            end else begin
                n_out.display_event = bvm_pkg::EV_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && (!r_out_valid || i_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op  <= i_data.kind;
                        r_a   <= i_data.first_operand;
                        r_b   <= i_data.second_operand;
                        r_idx <= 2'd0;
                        r_nrd <= read_count(i_data.kind);
                        r_err <= in_bad ? bvm_pkg::ERR_BAD_INDEX : bvm_pkg::ERR_NONE;
                        if (in_bad) begin
                            r_state <= S_DONE;
                        end else if (read_count(i_data.kind) == 3'd0) begin
                            r_state <= S_EXEC;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: r_state <= S_CAPT;
                S_CAPT: begin
                    r_opnd[r_idx] <= rf_rd_data;
                    r_idx         <= r_idx + 2'd1;
                    r_state       <= ({1'b0, r_idx} == r_nrd - 3'd1) ? S_EXEC : S_READ;
                end
                S_EXEC: r_state <= alu_req.start ? S_ALU : S_DONE;
                S_ALU: begin
                    if (alu_rsp.done) begin
                        if (alu_rsp.div_zero) begin
                            r_err <= bvm_pkg::ERR_DIV_ZERO;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out   <= n_out;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `BVM_ASSERT_ALWAYS(a_no_write_idle, !(rf_req.wr_en && r_state == S_IDLE), "write while idle")
    `BVM_ASSERT_ALWAYS(a_no_write_bad, !(rf_req.wr_en && r_err == bvm_pkg::ERR_BAD_INDEX), "write after bad index")
    `BVM_ASSERT(a_alu_done_state, alu_rsp.done |-> (r_state == S_ALU), "alu result outside wait state")
    `BVM_ASSERT(a_done_to_idle, (r_state == S_DONE && !r_out_valid) |=> (r_state == S_IDLE && o_valid), "result not loaded")

endmodule
